// ===== rtl/fsp_pkg.sv =====
package fsp_pkg;

    // action codes carried in an input word
    localparam logic [2:0] ACT_START   = 3'd0;
    localparam logic [2:0] ACT_TICK    = 3'd1;
    localparam logic [2:0] ACT_IDLE    = 3'd2;
    localparam logic [2:0] ACT_PRESENT = 3'd3;
    localparam logic [2:0] ACT_FAILED  = 3'd4;
    localparam logic [2:0] ACT_REDRAW  = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_STEP     = 2'd0;
    localparam logic [1:0] CFG_INTERVAL = 2'd1;
    localparam logic [1:0] CFG_CATCHUP  = 2'd2;

    // configuration reset values
    localparam logic [31:0] RST_STEP_NS     = 32'd16666667;
    localparam logic [31:0] RST_INTERVAL_NS = 32'd16666667;
    localparam logic [7:0]  RST_CATCHUP     = 8'd8;

    typedef struct packed {
        logic [2:0]  action;
        logic [63:0] now_ns;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  updates_due;
        logic [63:0] next_step_ns;
        logic        redraw_due;
        logic        dirty_flag;
        logic        redraw_pending;
    } t_out_word;

    // controller to datapath strobes
    typedef struct packed {
        logic load;
        logic exec;
        logic tick;
        logic emit;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic is_tick;
        logic tick_done;
    } t_dp_sts;

endpackage

// ===== rtl/fsp_ctrl.sv =====
module fsp_ctrl
    import fsp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_TICK,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // strobes decoded from state
    always_comb begin
        o_cmd      = '0;
        o_cmd.load = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec = (r_state == S_EXEC);
        o_cmd.tick = (r_state == S_TICK);
        o_cmd.emit = (r_state == S_EMIT) && w_out_free;
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_state <= i_sts.is_tick ? S_TICK : S_EMIT;
                end
                S_TICK: begin
                    if (i_sts.tick_done) r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase

            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // a word's result is registered only after the exec and emit states
    a_no_fast_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> !$rose(r_out_valid))
        else $error("result appeared one cycle after input");

    // a finished tick always proceeds to emit
    a_tick_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK && i_sts.tick_done) |=> (r_state == S_EMIT))
        else $error("tick did not move to emit");

    // a stalled output word is never overwritten
    a_emit_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_out_valid && !i_out_ready) |=>
            (r_state == S_EMIT && r_out_valid))
        else $error("emit overran a stalled word");

endmodule

// ===== rtl/fsp_dp.sv =====
module fsp_dp
    import fsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic [1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  t_in_word   i_in,
    input  t_dp_cmd    i_cmd,
    output t_dp_sts    o_sts,
    output t_out_word  o_out
);

    // configuration
    logic [31:0] r_step;
    logic [31:0] r_interval;
    logic [7:0]  r_max;

    // scheduler state
    logic [63:0] r_next;
    logic [63:0] r_last;
    logic        r_dirty;
    logic        r_redraw_req;
    logic [7:0]  r_steps;

    // per-word working registers
    logic [2:0]  r_act;
    logic [63:0] r_now;
    logic [63:0] r_now_step;
    logic [7:0]  r_cnt;
    logic        r_redraw;
    t_out_word   r_out;

    logic [63:0] w_step64;
    logic [63:0] w_interval64;
    logic [63:0] w_next_inc;
    logic [63:0] w_start_last;
    logic [63:0] w_since;
    logic [7:0]  w_cnt_inc;
    logic        w_due;
    logic        w_limit;
    logic        w_done;

    assign w_step64     = {32'd0, r_step};
    assign w_interval64 = {32'd0, r_interval};
    assign w_next_inc   = r_next + w_step64;
    assign w_start_last = (r_now >= w_interval64) ? (r_now - w_interval64) : 64'd0;
    assign w_since      = r_now - r_last;
    assign w_cnt_inc    = r_cnt + 8'd1;
    assign w_due        = (r_now >= r_next);
    assign w_limit      = (w_cnt_inc >= r_max);
    assign w_done       = !w_due || w_limit;

    assign o_sts.is_tick   = (r_act == ACT_TICK);
    assign o_sts.tick_done = w_done;
    assign o_out           = r_out;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= RST_STEP_NS;
            r_interval <= RST_INTERVAL_NS;
            r_max      <= RST_CATCHUP;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_STEP:     r_step     <= i_cfg_data;
                CFG_INTERVAL: r_interval <= i_cfg_data;
                CFG_CATCHUP:  r_max      <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // scheduler state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next       <= 64'd0;
            r_last       <= 64'd0;
            r_dirty      <= 1'b1;
            r_redraw_req <= 1'b0;
            r_steps      <= 8'd0;
        end else begin
            if (i_cmd.exec) begin
                case (r_act)
                    ACT_START: begin
                        r_next       <= r_now_step;
                        r_last       <= w_start_last;
                        r_dirty      <= 1'b1;
                        r_redraw_req <= 1'b0;
                        r_steps      <= 8'd0;
                    end
                    ACT_PRESENT: begin
                        r_last       <= r_now;
                        r_dirty      <= 1'b0;
                        r_redraw_req <= 1'b0;
                    end
                    ACT_FAILED: r_dirty      <= 1'b1;
                    ACT_REDRAW: r_redraw_req <= 1'b1;
                    default: ;
                endcase
            end
            // one catch-up step per cycle
            if (i_cmd.tick) begin
                if (w_due) begin
                    r_next <= w_limit ? r_now_step : w_next_inc;
                end
                if (w_done) begin
                    r_steps <= w_due ? w_cnt_inc : r_cnt;
                    if (w_due || (r_cnt != 8'd0)) r_dirty <= 1'b1;
                end
            end
        end
    end

    // working registers and output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act      <= i_in.action;
            r_now      <= i_in.now_ns;
            r_now_step <= i_in.now_ns + w_step64;
            r_cnt      <= 8'd0;
        end
        if (i_cmd.exec) begin
            r_redraw <= (r_act == ACT_IDLE) && r_dirty && (w_since >= w_interval64);
        end
        if (i_cmd.tick && w_due && !w_limit) begin
            r_cnt <= w_cnt_inc;
        end
        if (i_cmd.emit) begin
            r_out.updates_due    <= r_steps;
            r_out.next_step_ns   <= r_next;
            r_out.redraw_due     <= r_redraw;
            r_out.dirty_flag     <= r_dirty;
            r_out.redraw_pending <= r_redraw_req;
        end
    end

    // hitting the catch-up limit resynchronises to now plus one step
    a_limit_resync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.tick && w_due && w_limit) |=> (r_next == $past(r_now_step)))
        else $error("catch-up limit did not resync schedule");

    // any granted step leaves the frame dirty
    a_tick_dirty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.tick && w_done && (w_due || r_cnt != 8'd0)) |=> r_dirty)
        else $error("granted steps without dirty frame");

    // presented clears dirty and pending and records the time
    a_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_act == ACT_PRESENT) |=>
            (!r_dirty && !r_redraw_req && r_last == $past(r_now)))
        else $error("presented word mishandled");

endmodule

// ===== rtl/fixed_step_frame_pacer.sv =====
// Frame pacing scheduler with a bounded catch-up loop.
// Flow: each accepted word passes through the exec state and then the emit state, which
// registers the result; a tick word loops in the tick state until no step is due or the cap is hit.
// Only one word is in flight: the next is taken the cycle after the result is registered,
// and a stalled output word holds the emit state until the receiver takes it.
// Reset (synchronous, active low): registers to defaults, schedule zero, frame dirty.
module fixed_step_frame_pacer
    import fsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    // sequencer
    fsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // time arithmetic and scheduler state
    fsp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out       (o_out)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import fsp_pkg::*;

    // codes the block must ignore
    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;
    localparam logic [1:0] CFG_SPARE  = 2'd3;

    localparam logic [63:0] T_END = 64'hFFFF_FFFF_FFFF_FFFF;

    // receiver behaviour
    localparam int RX_ALWAYS  = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;

    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 5000;
    localparam int SETTLE       = 8;
    localparam int TAIL_CYCLES  = 300;
    localparam int REPORT_LIMIT = 200;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_word    i_in;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_word   o_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    fixed_step_frame_pacer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // pacer copy: registers and schedule
    logic [31:0] step_ns     = RST_STEP_NS;
    logic [31:0] interval_ns = RST_INTERVAL_NS;
    logic [7:0]  catchup     = RST_CATCHUP;
    logic [63:0] next_update = '0;
    logic [63:0] last_shown  = '0;
    logic        frame_dirty = 1'b1;
    logic        redraw_req  = 1'b0;
    logic [7:0]  granted     = '0;

    t_out_word   expected_words[$];
    int unsigned n_fail      = 0;
    int unsigned stall_count = 0;
    int unsigned burst_left  = 0;
    logic [63:0] scene_now   = '0;

    int          rx_mode     = RX_ALWAYS;
    bit          hold_req    = 1'b0;
    int unsigned hold_left   = 0;
    int unsigned rx_phase    = 0;

    // directed rows; typed rows carry their own expected word
    typedef struct packed {
        logic [2:0]  act;
        logic [63:0] now;
        logic        typed;
        logic [7:0]  due;
        logic [63:0] wait_ns;
        logic        rdue;
        logic        dflag;
        logic        pend;
    } t_dir_row;

    t_dir_row dir_rows [0:22] = '{
        '{ACT_IDLE,    64'd0,         1'b1, 8'd0, 64'd0,        1'b0, 1'b1, 1'b0},
        '{ACT_IDLE,    T_END,         1'b1, 8'd0, 64'd0,        1'b1, 1'b1, 1'b0},
        '{ACT_TICK,    64'd0,         1'b1, 8'd1, 64'd16666667, 1'b0, 1'b1, 1'b0},
        '{ACT_TICK,    T_END,         1'b1, 8'd8, 64'd16666666, 1'b0, 1'b1, 1'b0},
        '{ACT_REDRAW,  64'd0,         1'b1, 8'd8, 64'd16666666, 1'b0, 1'b1, 1'b1},
        '{ACT_PRESENT, 64'd100,       1'b1, 8'd8, 64'd16666666, 1'b0, 1'b0, 1'b0},
        '{ACT_IDLE,    T_END,         1'b1, 8'd8, 64'd16666666, 1'b0, 1'b0, 1'b0},
        '{ACT_FAILED,  64'd5,         1'b1, 8'd8, 64'd16666666, 1'b0, 1'b1, 1'b0},
        '{ACT_SPARE6,  T_END,         1'b1, 8'd8, 64'd16666666, 1'b0, 1'b1, 1'b0},
        '{ACT_SPARE7,  64'd0,         1'b1, 8'd8, 64'd16666666, 1'b0, 1'b1, 1'b0},
        '{ACT_IDLE,    64'd16666766,  1'b1, 8'd8, 64'd16666666, 1'b0, 1'b1, 1'b0},
        '{ACT_IDLE,    64'd16666767,  1'b1, 8'd8, 64'd16666666, 1'b1, 1'b1, 1'b0},
        '{ACT_START,   64'd0,         1'b1, 8'd0, 64'd16666667, 1'b0, 1'b1, 1'b0},
        '{ACT_START,   T_END,         1'b1, 8'd0, 64'd16666666, 1'b0, 1'b1, 1'b0},
        '{ACT_IDLE,    T_END,         1'b1, 8'd0, 64'd16666666, 1'b1, 1'b1, 1'b0},
        '{ACT_TICK,    64'd16666665,  1'b1, 8'd0, 64'd16666666, 1'b0, 1'b1, 1'b0},
        '{ACT_TICK,    64'd16666666,  1'b1, 8'd1, 64'd33333333, 1'b0, 1'b1, 1'b0},
        '{ACT_PRESENT, 64'd33333333,  1'b0, 8'd0, 64'd0,        1'b0, 1'b0, 1'b0},
        '{ACT_TICK,    64'd200000000, 1'b0, 8'd0, 64'd0,        1'b0, 1'b0, 1'b0},
        '{ACT_REDRAW,  64'd200000001, 1'b0, 8'd0, 64'd0,        1'b0, 1'b0, 1'b0},
        '{ACT_START,   64'd1000,      1'b0, 8'd0, 64'd0,        1'b0, 1'b0, 1'b0},
        '{ACT_TICK,    64'd50001005,  1'b0, 8'd0, 64'd0,        1'b0, 1'b0, 1'b0},
        '{ACT_IDLE,    64'd50001005,  1'b0, 8'd0, 64'd0,        1'b0, 1'b0, 1'b0}
    };

    // predicts the result word of one action and updates the pacer copy
    function automatic t_out_word advance_pacer(input t_in_word w);
        t_out_word   r;
        int unsigned steps;
        logic        redraw;
        steps  = 0;
        redraw = 1'b0;
        case (w.action)
            ACT_START: begin
                next_update = w.now_ns + 64'(step_ns);
                last_shown  = (w.now_ns >= 64'(interval_ns)) ? w.now_ns - 64'(interval_ns) : '0;
                frame_dirty = 1'b1;
                redraw_req  = 1'b0;
                granted     = '0;
            end
            ACT_TICK: begin
                // bounded catch-up, resync to now + step when the cap is hit
                while (w.now_ns >= next_update) begin
                    steps++;
                    next_update = next_update + 64'(step_ns);
                    if (steps >= catchup) begin
                        next_update = w.now_ns + 64'(step_ns);
                        break;
                    end
                end
                if (steps > 0) frame_dirty = 1'b1;
                granted = steps[7:0];
            end
            ACT_IDLE: begin
                redraw = frame_dirty && ((w.now_ns - last_shown) >= 64'(interval_ns));
            end
            ACT_PRESENT: begin
                last_shown  = w.now_ns;
                frame_dirty = 1'b0;
                redraw_req  = 1'b0;
            end
            ACT_FAILED: frame_dirty = 1'b1;
            ACT_REDRAW: redraw_req = 1'b1;
            default: ;
        endcase
        r.updates_due    = granted;
        r.next_step_ns   = next_update;
        r.redraw_due     = redraw;
        r.dirty_flag     = frame_dirty;
        r.redraw_pending = redraw_req;
        return r;
    endfunction

    // next word: mostly plausible frame-loop traffic, some noise
    function automatic t_in_word make_word();
        t_in_word    w;
        logic [63:0] span;
        logic [63:0] delta;
        int unsigned pick;
        span = 64'(step_ns);
        if ($urandom_range(0, 99) < 10) begin
            w.action = 3'($urandom_range(0, 7));
            w.now_ns = {$urandom, $urandom};
            return w;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55)      delta = 64'($urandom) % (2 * span + 1);
        else if (pick < 80) delta = span * 64'($urandom_range(0, int'(catchup) + 3))
                                    + 64'($urandom_range(0, 3));
        else if (pick < 95) delta = '0;
        else                delta = {$urandom, $urandom};
        scene_now = scene_now + delta;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            w.action  = ACT_START;
            scene_now = $urandom_range(0, 1) ? {$urandom, $urandom} : {32'hFFFF_FFFF, $urandom};
        end
        else if (pick < 40) w.action = ACT_TICK;
        else if (pick < 65) w.action = ACT_IDLE;
        else if (pick < 80) w.action = ACT_PRESENT;
        else if (pick < 88) w.action = ACT_REDRAW;
        else if (pick < 96) w.action = ACT_FAILED;
        else                w.action = $urandom_range(0, 1) ? ACT_SPARE6 : ACT_SPARE7;
        w.now_ns = scene_now;
        return w;
    endfunction

    task automatic send_word(input t_in_word w, input bit typed, input t_out_word typed_res);
        t_out_word pred;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in       <= w;
        do @(posedge i_clk); while (!o_in_ready);
        pred = advance_pacer(w);
        expected_words.push_back(typed ? typed_res : pred);
    endtask

    // bursts of words with random gaps between them
    task automatic pace_sender(input bit no_gaps);
        int unsigned gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 16);
            gap = (no_gaps || $urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_STEP:     step_ns     = data;
            CFG_INTERVAL: interval_ns = data;
            CFG_CATCHUP:  catchup     = data[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one configuration setting followed by random traffic
    task automatic run_phase(input logic [31:0] step, input logic [31:0] interval,
                             input logic [31:0] cap_word, input int unsigned n_items,
                             input int rxm, input bit no_gaps,
                             input int hold_at, input int pause_at);
        t_in_word w;
        wait_drained();
        write_reg(CFG_STEP, step);
        write_reg(CFG_INTERVAL, interval);
        write_reg(CFG_CATCHUP, cap_word);
        if ($urandom_range(0, 1)) write_reg(CFG_SPARE, {$urandom});
        rx_mode   = rxm;
        scene_now = {$urandom, $urandom};
        w.action  = ACT_START;
        w.now_ns  = scene_now;
        send_word(w, 1'b0, '0);
        for (int i = 0; i < n_items; i++) begin
            if (i == hold_at) hold_req = 1'b1;
            if (i == pause_at) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                while (expected_words.size() != 0) @(posedge i_clk);
            end
            pace_sender(no_gaps);
            send_word(make_word(), 1'b0, '0);
        end
    endtask

    // receiver stall pattern, with one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: i_out_ready <= 1'b1;
                RX_RANDOM: i_out_ready <= ($urandom_range(0, 3) != 0);
                default: begin
                    rx_phase <= rx_phase + 1;
                    i_out_ready <= (rx_phase % 7) < 4;
                end
            endcase
        end
    end

    task automatic check_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            n_fail++;
            if (n_fail <= REPORT_LIMIT)
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, fname, want, got);
        end
    endtask

    // compare each result word with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                n_fail++;
                if (n_fail <= REPORT_LIMIT)
                    $display("%0t ns: unexpected result word, expected none, actual %0h",
                             $time, o_out);
            end else begin
                want = expected_words.pop_front();
                check_field("updates_due", 64'(want.updates_due), 64'(o_out.updates_due));
                check_field("next_step_ns", want.next_step_ns, o_out.next_step_ns);
                check_field("redraw_due", 64'(want.redraw_due), 64'(o_out.redraw_due));
                check_field("dirty_flag", 64'(want.dirty_flag), 64'(o_out.dirty_flag));
                check_field("redraw_pending", 64'(want.redraw_pending),
                            64'(o_out.redraw_pending));
            end
        end
    end

    // watchdog: cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    initial begin
        t_in_word  w;
        t_out_word res;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_STEP;
        i_cfg_data  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part under the reset configuration
        rx_mode = RX_RANDOM;
        foreach (dir_rows[k]) begin
            w.action           = dir_rows[k].act;
            w.now_ns           = dir_rows[k].now;
            res.updates_due    = dir_rows[k].due;
            res.next_step_ns   = dir_rows[k].wait_ns;
            res.redraw_due     = dir_rows[k].rdue;
            res.dirty_flag     = dir_rows[k].dflag;
            res.redraw_pending = dir_rows[k].pend;
            pace_sender(1'b0);
            send_word(w, dir_rows[k].typed, res);
        end

        // random part over several settings, extremes included
        run_phase(RST_STEP_NS, RST_INTERVAL_NS, 32'(RST_CATCHUP), 150, RX_RANDOM, 1'b0, -1, -1);
        run_phase(32'd10, 32'd25, 32'd3, 200, RX_PATTERN, 1'b0, 60, -1);
        run_phase(32'd1, 32'd1, 32'd255, 100, RX_RANDOM, 1'b0, -1, -1);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 150, RX_PATTERN, 1'b0, -1, -1);
        // zero step, zero interval and a zero catch-up cap
        run_phase(32'd0, 32'd0, 32'd0, 100, RX_RANDOM, 1'b0, -1, -1);
        run_phase(32'($urandom_range(1, 5000)), 32'($urandom_range(1, 9000)),
                  32'($urandom_range(1, 12)), 200, RX_ALWAYS, 1'b1, -1, -1);
        // catch-up word with junk above bit 7
        run_phase(32'd16666667, 32'd33333333, 32'hFFFF_FF08, 250, RX_RANDOM, 1'b0, -1, 120);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// ===== fixed_step_frame_pacer.f =====
rtl/fsp_pkg.sv
rtl/fsp_ctrl.sv
rtl/fsp_dp.sv
rtl/fixed_step_frame_pacer.sv
tb/tb_top.sv
